[hdl/ksta_pkg.sv]
// Package for the keyed sensor table: field widths, item structs, result codes
// and the command/status structs between the controller and the datapath.
// No dependencies.
package ksta_pkg;

	// Default table depth
	localparam int unsigned MAX_ENTRIES_DEF = 16;

	// Field widths
	localparam int unsigned KEY_W  = 64;
	localparam int unsigned RD_W   = 16;
	localparam int unsigned TM_W   = 32;
	localparam int unsigned LIVE_W = 5;
	localparam int unsigned IVL_W  = 16;
	localparam int unsigned MUL_W  = 8;
	localparam int unsigned TMO_W  = IVL_W + MUL_W;

	// Configuration port
	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;
	localparam logic        REG_INTERVAL = 1'b0;
	localparam logic        REG_MULT     = 1'b1;
	localparam logic [IVL_W-1:0] INTERVAL_RST = 16'd10;
	localparam logic [MUL_W-1:0] MULT_RST     = 8'd3;

	// Input commands
	localparam logic CMD_REPORT = 1'b0;
	localparam logic CMD_SWEEP  = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_ACK     = 2'd0;
	localparam logic [1:0] KIND_KEPT    = 2'd1;
	localparam logic [1:0] KIND_REMOVED = 2'd2;
	localparam logic [1:0] KIND_DONE    = 2'd3;

	// Ack status codes
	localparam logic [1:0] ST_UPDATED  = 2'd0;
	localparam logic [1:0] ST_INSERTED = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	typedef struct packed {
		logic                   command;
		logic [KEY_W-1:0]       sensor_key;
		logic signed [RD_W-1:0] reading;
		logic [TM_W-1:0]        read_time;
		logic [TM_W-1:0]        now_time;
	} in_item_t;

	typedef struct packed {
		logic [1:0]             kind;
		logic [1:0]             status;
		logic [KEY_W-1:0]       entry_key;
		logic signed [RD_W-1:0] entry_reading;
		logic [TM_W-1:0]        entry_time;
		logic [LIVE_W-1:0]      live_count;
		logic                   last;
	} out_item_t;

	// One stored record
	typedef struct packed {
		logic [KEY_W-1:0]       key;
		logic signed [RD_W-1:0] reading;
		logic [TM_W-1:0]        stamp;
	} rec_t;

	// Controller to datapath
	typedef struct packed {
		logic       in_load;
		logic       rd_en;
		logic       wr_en;
		logic       wr_from_in;
		logic       out_load;
		logic [1:0] out_kind;
		logic [1:0] out_status;
		logic       out_last;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic key_hit;
		logic age_ok;
		logic out_free;
	} dp_stat_t;

endpackage

[hdl/ksta_item_if.sv]
// Input channel of the keyed sensor table: valid/ready plus one input item.
// Depends on ksta_pkg.
interface ksta_item_if
	import ksta_pkg::*;
();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/ksta_result_if.sv]
// Result channel of the keyed sensor table: valid/ready plus one result item.
// Depends on ksta_pkg.
interface ksta_result_if
	import ksta_pkg::*;
();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/ksta_dpath.sv]
// Datapath of the keyed sensor table: input latch, record memory with
// registered read, key match, age check and the result output register.
// Depends on ksta_pkg and ksta_result_if.
module ksta_dpath
	import ksta_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
	localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	input  logic [AW-1:0]     rd_addr,
	input  logic [AW-1:0]     wr_addr,
	input  logic [LIVE_W-1:0] live,
	input  logic [IVL_W-1:0]  interval,
	input  logic [MUL_W-1:0]  mult,
	input  in_item_t          item_data,
	output dp_stat_t          stat,
	ksta_result_if.source     result
);

	in_item_t          in_q;
	rec_t              mem_q [MAX_ENTRIES];
	rec_t              rdata_q;
	rec_t              wdata;
	logic [TMO_W-1:0]  timeout_q;
	logic [TM_W-1:0]   age;
	logic              ovalid_q;
	out_item_t         opay_q;
	out_item_t         onext;

	// Input latch
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			in_q <= item_data;
		end
	end

	// Expiry timeout, product of the two settings
	always_ff @(posedge clk) begin
		timeout_q <= interval * mult;
	end

	// Record memory: one write and one registered read per cycle
	assign wdata = cmd.wr_from_in ? rec_t'{key: in_q.sensor_key, reading: in_q.reading,
		stamp: in_q.read_time} : rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	// Match and age checks on the read record
	assign age = in_q.now_time - rdata_q.stamp;
	assign stat = dp_stat_t'{
		key_hit:  (rdata_q.key == in_q.sensor_key),
		age_ok:   (age <= TM_W'(timeout_q)),
		out_free: (!ovalid_q || result.ready)
	};

	// Result item assembly
	always_comb begin
		onext = '0;
		onext.kind       = cmd.out_kind;
		onext.status     = cmd.out_status;
		onext.live_count = live;
		onext.last       = cmd.out_last;
		case (cmd.out_kind)
			KIND_ACK: begin
				onext.entry_key = in_q.sensor_key;
			end
			KIND_KEPT, KIND_REMOVED: begin
				onext.entry_key     = rdata_q.key;
				onext.entry_reading = rdata_q.reading;
				onext.entry_time    = rdata_q.stamp;
			end
			default: begin
				onext.entry_key = '0;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			ovalid_q <= 1'b1;
		end else if (result.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			opay_q <= onext;
		end
	end

	assign result.valid = ovalid_q;
	assign result.data  = opay_q;

endmodule

[hdl/ksta_ctrl.sv]
// Controller of the keyed sensor table: sequences the key scan, the age pass
// and the listing/compaction pass, and owns the entry count and keep flags.
// Depends on ksta_pkg.
module ksta_ctrl
	import ksta_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
	localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1),
	localparam int unsigned IW = $clog2(MAX_ENTRIES + 2)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_cmd,
	output logic              item_ready,
	input  dp_stat_t          stat,
	output dp_cmd_t           cmd,
	output logic [AW-1:0]     rd_addr,
	output logic [AW-1:0]     wr_addr,
	output logic [LIVE_W-1:0] live
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SCAN  = 7'b0000010,
		S_RFIN  = 7'b0000100,
		S_AGE   = 7'b0001000,
		S_EMRD  = 7'b0010000,
		S_EMOUT = 7'b0100000,
		S_SFIN  = 7'b1000000
	} state_t;

	state_t                 state_q, state_d;
	logic [IW-1:0]          idx_q;
	logic [IW-1:0]          idx_inc;
	logic                   rvld_q;
	logic [AW-1:0]          ridx_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          count_inc;
	logic [CW-1:0]          kept_q;
	logic [CW-1:0]          wptr_q;
	logic                   hit_q;
	logic [AW-1:0]          hidx_q;
	logic [MAX_ENTRIES-1:0] keep_q;
	logic                   idx_lt;
	logic                   scan_end;
	logic                   full;
	logic                   cur_keep;
	logic                   last_entry;

	assign idx_inc    = idx_q + 1'b1;
	assign count_inc  = count_q + 1'b1;
	assign idx_lt     = idx_q < IW'(count_q);
	assign scan_end   = !rvld_q && !idx_lt;
	assign full       = (count_q == CW'(MAX_ENTRIES));
	assign cur_keep   = keep_q[idx_q[AW-1:0]];
	assign last_entry = !(idx_inc < IW'(count_q));

	// Commands and next state
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		rd_addr    = idx_q[AW-1:0];
		wr_addr    = '0;
		live       = LIVE_W'(count_q);
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.in_load = 1'b1;
					state_d = (item_cmd == CMD_SWEEP) ? S_AGE : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.rd_en = idx_lt;
				if (rvld_q && stat.key_hit) begin
					state_d = S_RFIN;
				end else if (scan_end) begin
					state_d = S_RFIN;
				end
			end
			S_RFIN: begin
				cmd.out_kind   = KIND_ACK;
				cmd.out_last   = 1'b1;
				cmd.wr_from_in = 1'b1;
				if (hit_q) begin
					cmd.out_status = ST_UPDATED;
					wr_addr        = hidx_q;
				end else if (full) begin
					cmd.out_status = ST_FULL;
				end else begin
					cmd.out_status = ST_INSERTED;
					wr_addr        = count_q[AW-1:0];
					live           = LIVE_W'(count_inc);
				end
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.wr_en    = (cmd.out_status != ST_FULL);
					state_d      = S_IDLE;
				end
			end
			S_AGE: begin
				cmd.rd_en = idx_lt;
				if (scan_end) begin
					state_d = (count_q == '0) ? S_SFIN : S_EMRD;
				end
			end
			S_EMRD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_EMOUT;
			end
			S_EMOUT: begin
				cmd.out_kind = cur_keep ? KIND_KEPT : KIND_REMOVED;
				live         = LIVE_W'(kept_q);
				wr_addr      = wptr_q[AW-1:0];
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.wr_en    = cur_keep;
					state_d      = last_entry ? S_SFIN : S_EMRD;
				end
			end
			S_SFIN: begin
				cmd.out_kind = KIND_DONE;
				cmd.out_last = 1'b1;
				live         = LIVE_W'(kept_q);
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Counters, flags and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			rvld_q  <= 1'b0;
			ridx_q  <= '0;
			count_q <= '0;
			kept_q  <= '0;
			wptr_q  <= '0;
			hit_q   <= 1'b0;
			hidx_q  <= '0;
			keep_q  <= '0;
		end else begin
			state_q <= state_d;
			// read pipeline tag for the scan passes
			rvld_q  <= (state_q == S_SCAN || state_q == S_AGE) && idx_lt;
			ridx_q  <= idx_q[AW-1:0];
			case (state_q)
				S_IDLE: begin
					idx_q  <= '0;
					kept_q <= '0;
					wptr_q <= '0;
					hit_q  <= 1'b0;
				end
				S_SCAN: begin
					idx_q <= idx_inc;
					if (rvld_q && stat.key_hit) begin
						hit_q  <= 1'b1;
						hidx_q <= ridx_q;
					end
				end
				S_RFIN: begin
					if (stat.out_free && !hit_q && !full) begin
						count_q <= count_inc;
					end
				end
				S_AGE: begin
					if (scan_end) begin
						idx_q <= '0;
					end else begin
						idx_q <= idx_inc;
					end
					if (rvld_q) begin
						keep_q[ridx_q] <= stat.age_ok;
						if (stat.age_ok) begin
							kept_q <= kept_q + 1'b1;
						end
					end
				end
				S_EMOUT: begin
					if (stat.out_free) begin
						idx_q <= idx_inc;
						if (cur_keep) begin
							wptr_q <= wptr_q + 1'b1;
						end
					end
				end
				S_SFIN: begin
					if (stat.out_free) begin
						count_q <= kept_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[hdl/keyed_sensor_table_with_aging_top.sv]
// Keyed sensor table with aging. Upper-level wiring of controller and
// datapath, plus the configuration registers and their APB-style port.
// Depends on ksta_pkg, ksta_item_if, ksta_result_if, ksta_ctrl, ksta_dpath.
//
// Usage: input items arrive on "item", results leave on "result"; both are
// valid/ready channels and a transfer happens when valid and ready are high.
// A report (command 0) looks up its key, updates or appends a record (neither
// when the table is full) and gives one ack. A sweep (command 1) gives one
// kept/removed item per stored record in table order, then a done item;
// expired records are squeezed out. Timing: one item at a time. A report
// scans the keys, one record a cycle through the registered memory read, then
// loads the ack; a hit ends the scan early. A sweep runs the age pass, then
// reads and lists each record while compacting, then loads the done item.
// The next item is taken once the last result is loaded into the output
// register, even while that result waits.
// Reset empties the table; interval and multiplier return to 10 and 3.
// A stalled receiver holds the output register and the sequencer waits.
// Settings are written at byte 0 (interval) and 4 (multiplier); writing them
// only while idle is up to the user, as the block leaves it unchecked.
module keyed_sensor_table_with_aging_top
	import ksta_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	ksta_item_if.sink         item,
	ksta_result_if.source     result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	logic [IVL_W-1:0]  interval_q;
	logic [MUL_W-1:0]  mult_q;
	logic              reg_sel;
	logic              cfg_wr;
	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [LIVE_W-1:0] live;

	// Configuration registers
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RST;
			mult_q     <= MULT_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_INTERVAL: interval_q <= pwdata[IVL_W-1:0];
				REG_MULT:     mult_q     <= pwdata[MUL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_INTERVAL: prdata = APB_DW'(interval_q);
			REG_MULT:     prdata = APB_DW'(mult_q);
			default:      prdata = '0;
		endcase
	end

	ksta_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_cmd   (item.data.command),
		.item_ready (item.ready),
		.stat       (stat),
		.cmd        (cmd),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.live       (live)
	);

	ksta_dpath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.live      (live),
		.interval  (interval_q),
		.mult      (mult_q),
		.item_data (item.data),
		.stat      (stat),
		.result    (result)
	);

endmodule
